// File: rtl/core/u8dv_pkg.sv
// Shared types and constants for the UTF-8 stream decoder and validator.
`default_nettype none

package u8dv_pkg;

    localparam int OFFSET_BITS_DEFAULT = 16;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int LEN_W   = 3;
    localparam int START_W = 16;
    localparam int KIND_W  = 2;

    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD2_LO   = 8'hC2;
    localparam logic [7:0] LEAD2_HI   = 8'hDF;
    localparam logic [7:0] LEAD3_LO   = 8'hE0;
    localparam logic [7:0] LEAD3_HI   = 8'hEF;
    localparam logic [7:0] LEAD_SURR  = 8'hED;
    localparam logic [7:0] LEAD4_LO   = 8'hF0;
    localparam logic [7:0] LEAD4_HI   = 8'hF4;
    localparam logic [7:0] CONT_LO    = 8'h80;
    localparam logic [7:0] CONT_HI    = 8'hBF;
    localparam logic [7:0] E0_LO      = 8'hA0;
    localparam logic [7:0] ED_HI      = 8'h9F;
    localparam logic [7:0] F0_LO      = 8'h90;
    localparam logic [7:0] F4_HI      = 8'h8F;
    localparam logic [7:0] PAYLOAD_M  = 8'h3F;

    localparam logic [LEN_W-1:0] SEQ_LEN1 = 3'd1;
    localparam logic [LEN_W-1:0] SEQ_LEN2 = 3'd2;
    localparam logic [LEN_W-1:0] SEQ_LEN3 = 3'd3;
    localparam logic [LEN_W-1:0] SEQ_LEN4 = 3'd4;

    localparam logic [KIND_W-1:0] ERR_BAD_LEAD  = 2'd0;
    localparam logic [KIND_W-1:0] ERR_NO_CONT   = 2'd1;
    localparam logic [KIND_W-1:0] ERR_BOUNDS    = 2'd2;
    localparam logic [KIND_W-1:0] ERR_TRUNCATED = 2'd3;

    typedef struct packed {
        logic [1:0]      pending;
        logic [CP_W-1:0] partial;
        logic [LEN_W-1:0] seq_len;
        logic            second_next;
        logic [7:0]      bound_lo;
        logic [7:0]      bound_hi;
        logic            failed;
    } t_state;

    localparam t_state STATE_RESET = '{
        pending:     2'd0,
        partial:     '0,
        seq_len:     '0,
        second_next: 1'b0,
        bound_lo:    CONT_LO,
        bound_hi:    CONT_HI,
        failed:      1'b0
    };

    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic [LEN_W-1:0]   code_length;
        logic               code_ready;
        logic [START_W-1:0] code_start;
        logic               error_seen;
        logic [KIND_W-1:0]  error_kind;
        logic               done_res;
        logic               string_valid;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/u8dv_if.sv
// Valid/ready channel interfaces for the input byte and the decoded result.
`default_nettype none

interface u8dv_in_if;
    import u8dv_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_string;
    modport source (output valid, data_byte, end_of_string, input ready);
    modport sink   (input valid, data_byte, end_of_string, output ready);
endinterface

interface u8dv_out_if;
    import u8dv_pkg::*;
    logic               valid;
    logic               ready;
    logic [CP_W-1:0]    code_point;
    logic [LEN_W-1:0]   code_length;
    logic               code_ready;
    logic [START_W-1:0] code_start;
    logic               error_seen;
    logic [KIND_W-1:0]  error_kind;
    logic               done_res;
    logic               string_valid;
    modport source (output valid, code_point, code_length, code_ready, code_start,
                    error_seen, error_kind, done_res, string_valid, input ready);
    modport sink   (input valid, code_point, code_length, code_ready, code_start,
                    error_seen, error_kind, done_res, string_valid, output ready);
endinterface

`default_nettype wire

// File: rtl/core/u8dv_step.sv
// Per-byte decode step: next decoder state and the optional result for one beat.
`default_nettype none

module u8dv_step #(
    parameter int OFFSET_BITS = u8dv_pkg::OFFSET_BITS_DEFAULT
) (
    input  wire u8dv_pkg::t_state     i_state,
    input  wire [OFFSET_BITS-1:0]     i_pos,
    input  wire [OFFSET_BITS-1:0]     i_seq_start,
    input  wire [7:0]                 i_byte,
    input  wire                       i_last,
    output u8dv_pkg::t_state          o_state,
    output logic [OFFSET_BITS-1:0]    o_pos,
    output logic [OFFSET_BITS-1:0]    o_seq_start,
    output logic                      o_emit,
    output u8dv_pkg::t_result         o_result
);
    import u8dv_pkg::*;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [1:0]  pend_dec;
    logic [31:0] pos_w;
    logic [31:0] start_w;

    assign pos_w    = 32'(i_pos);
    assign start_w  = 32'(i_seq_start);
    assign lo       = i_state.second_next ? i_state.bound_lo : CONT_LO;
    assign hi       = i_state.second_next ? i_state.bound_hi : CONT_HI;
    assign pend_dec = i_state.pending - 2'd1;

    always_comb begin
        o_state     = i_state;
        o_pos       = i_pos;
        o_seq_start = i_seq_start;
        o_emit      = 1'b0;
        o_result    = '0;

        if (!i_state.failed) begin
            if (i_state.pending == 2'd0) begin
                o_seq_start = i_pos;
                if (!i_byte[7]) begin
                    o_result.code_point  = CP_W'(i_byte);
                    o_result.code_length = SEQ_LEN1;
                    o_result.code_ready  = 1'b1;
                    o_result.code_start  = pos_w[START_W-1:0];
                    o_emit               = 1'b1;
                end else if (i_byte >= LEAD2_LO && i_byte <= LEAD2_HI) begin
                    o_state.seq_len     = SEQ_LEN2;
                    o_state.pending     = 2'd1;
                    o_state.partial     = CP_W'(i_byte[4:0]);
                    o_state.second_next = 1'b1;
                    o_state.bound_lo    = CONT_LO;
                    o_state.bound_hi    = CONT_HI;
                end else if (i_byte >= LEAD3_LO && i_byte <= LEAD3_HI) begin
                    o_state.seq_len     = SEQ_LEN3;
                    o_state.pending     = 2'd2;
                    o_state.partial     = CP_W'(i_byte[3:0]);
                    o_state.second_next = 1'b1;
                    o_state.bound_lo    = (i_byte == LEAD3_LO) ? E0_LO : CONT_LO;
                    o_state.bound_hi    = (i_byte == LEAD_SURR) ? ED_HI : CONT_HI;
                end else if (i_byte >= LEAD4_LO && i_byte <= LEAD4_HI) begin
                    o_state.seq_len     = SEQ_LEN4;
                    o_state.pending     = 2'd3;
                    o_state.partial     = CP_W'(i_byte[2:0]);
                    o_state.second_next = 1'b1;
                    o_state.bound_lo    = (i_byte == LEAD4_LO) ? F0_LO : CONT_LO;
                    o_state.bound_hi    = (i_byte == LEAD4_HI) ? F4_HI : CONT_HI;
                end else begin
                    o_state.failed       = 1'b1;
                    o_result.error_seen  = 1'b1;
                    o_result.error_kind  = ERR_BAD_LEAD;
                    o_emit               = 1'b1;
                end
            end else begin
                if ((i_byte & CONT_MASK) != CONT_TAG) begin
                    o_state.failed      = 1'b1;
                    o_state.pending     = 2'd0;
                    o_result.error_seen = 1'b1;
                    o_result.error_kind = ERR_NO_CONT;
                    o_emit              = 1'b1;
                end else if (i_byte < lo || i_byte > hi) begin
                    o_state.failed      = 1'b1;
                    o_state.pending     = 2'd0;
                    o_result.error_seen = 1'b1;
                    o_result.error_kind = ERR_BOUNDS;
                    o_emit              = 1'b1;
                end else begin
                    o_state.partial     = {i_state.partial[CP_W-7:0], i_byte[5:0]};
                    o_state.pending     = pend_dec;
                    o_state.second_next = 1'b0;
                    if (pend_dec == 2'd0) begin
                        o_result.code_point  = {i_state.partial[CP_W-7:0], i_byte[5:0]};
                        o_result.code_length = i_state.seq_len;
                        o_result.code_ready  = 1'b1;
                        o_result.code_start  = start_w[START_W-1:0];
                        o_emit               = 1'b1;
                    end
                end
            end
        end

        if (i_last) begin
            if (!o_state.failed && o_state.pending != 2'd0) begin
                o_state.failed      = 1'b1;
                o_result.error_seen = 1'b1;
                o_result.error_kind = ERR_TRUNCATED;
            end
            o_result.done_res     = 1'b1;
            o_result.string_valid = !o_state.failed;
            o_emit                = 1'b1;
            o_state               = STATE_RESET;
            o_pos                 = '0;
            o_seq_start           = '0;
        end else if (i_pos != POS_MAX) begin
            o_pos = i_pos + 1'b1;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/utf8_stream_decoder_validator.sv
// Top level of the streaming UTF-8 decoder and validator.
// Takes one byte beat per cycle while i_in.ready is high and applies strict
// UTF-8 rules. A beat yields a result beat when a scalar completes, at the
// first error of a string, and always on the last byte of a string, which
// carries the verdict. Each byte goes through one step of decode logic between
// the decoder state registers and a result register, so a byte is accepted in
// every cycle that the result register is empty or being drained; a result is
// registered in the cycle after its byte. The byte offset counter holds at
// 2^OFFSET_BITS-1; code_start gives its low 16 bits.
`default_nettype none

module utf8_stream_decoder_validator #(
    parameter int OFFSET_BITS = u8dv_pkg::OFFSET_BITS_DEFAULT
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    u8dv_in_if.sink     i_in,
    u8dv_out_if.source  o_out
);
    import u8dv_pkg::*;

    t_state                 r_state;
    t_state                 n_state;
    logic [OFFSET_BITS-1:0] r_pos;
    logic [OFFSET_BITS-1:0] n_pos;
    logic [OFFSET_BITS-1:0] r_seq_start;
    logic [OFFSET_BITS-1:0] n_seq_start;
    logic                   r_out_valid;
    t_result                r_out;
    t_result                step_result;
    logic                   step_emit;
    logic                   in_acc;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    u8dv_step #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_step (
        .i_state     (r_state),
        .i_pos       (r_pos),
        .i_seq_start (r_seq_start),
        .i_byte      (i_in.data_byte),
        .i_last      (i_in.end_of_string),
        .o_state     (n_state),
        .o_pos       (n_pos),
        .o_seq_start (n_seq_start),
        .o_emit      (step_emit),
        .o_result    (step_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_RESET;
            r_pos       <= '0;
            r_seq_start <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_state     <= n_state;
                r_pos       <= n_pos;
                r_seq_start <= n_seq_start;
            end
            if (in_acc && step_emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && step_emit) begin
            r_out <= step_result;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.code_point   = r_out.code_point;
    assign o_out.code_length  = r_out.code_length;
    assign o_out.code_ready   = r_out.code_ready;
    assign o_out.code_start   = r_out.code_start;
    assign o_out.error_seen   = r_out.error_seen;
    assign o_out.error_kind   = r_out.error_kind;
    assign o_out.done_res     = r_out.done_res;
    assign o_out.string_valid = r_out.string_valid;

`ifndef ASSERT_OFF
    a_err_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.error_seen |-> !r_out.code_ready && !r_out.string_valid)
        else $error("error beat also carries a scalar or a pass verdict");

    a_code_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.code_ready |-> r_out.code_length != 3'd0)
        else $error("scalar beat with zero length");

    a_verdict_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.string_valid |-> r_out.done_res)
        else $error("verdict without end of string");

    a_string_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.end_of_string |=>
            r_state.pending == 2'd0 && !r_state.failed && r_pos == '0 && r_out_valid)
        else $error("decoder state not cleared after last byte");
`endif

endmodule

`default_nettype wire
